// ----- hdl/sap_pkg.sv -----
// ----------------------------------------------------------------------------
// sap_pkg
// Shared types and constants of the signed axis projection block.
// ----------------------------------------------------------------------------
package sap_pkg;

  localparam int AXIS_COUNT = 3;
  localparam int COMP_W     = 16;
  localparam int AXIS_W     = 3 * COMP_W;
  localparam int RES_W      = 17;
  localparam int NORM_W     = 32;
  localparam int MAG_W      = 32;
  localparam int SQ_W       = 2 * MAG_W + 2;
  localparam int QUOT_W     = 34;
  localparam int ROOT_W     = QUOT_W / 2;
  localparam int SQRT_REM_W = ROOT_W + 4;
  localparam int DOT_STAGES = 4;
  localparam int LATENCY    = DOT_STAGES + QUOT_W + ROOT_W + 1;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic signed [RES_W-1:0]  res_t;
  typedef logic [AXIS_W-1:0]        axis_t;
  typedef logic [NORM_W-1:0]        norm_t;

  typedef enum logic [1:0] {
    REG_VERTICAL = 2'd0,
    REG_FORWARD  = 2'd1,
    REG_LATERAL  = 2'd2
  } reg_idx_t;

endpackage

// ----- hdl/sap_div.sv -----
// ----------------------------------------------------------------------------
// sap_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module sap_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [sap_pkg::SQ_W-1:0]    dividend,
  input  sap_pkg::norm_t              divisor,
  input  logic                        tag_in,
  output logic [sap_pkg::QUOT_W-1:0]  quot,
  output logic                        tag_out
);
  import sap_pkg::*;

  logic [NORM_W-1:0] rem_r  [QUOT_W];
  logic [QUOT_W-1:0] low_r  [QUOT_W];
  logic [QUOT_W-1:0] quot_r [QUOT_W];
  logic              tag_r  [QUOT_W];

  genvar i;
  generate
    for (i = 0; i < QUOT_W; i++) begin : g_stage
      logic [NORM_W-1:0] rem_prev;
      logic [QUOT_W-1:0] low_prev;
      logic [QUOT_W-1:0] quot_prev;
      logic              tag_prev;
      logic [NORM_W:0]   trial;
      logic              ge;
      if (i == 0) begin : g_first
        assign rem_prev  = dividend[SQ_W-1:QUOT_W];
        assign low_prev  = dividend[QUOT_W-1:0];
        assign quot_prev = '0;
        assign tag_prev  = tag_in;
      end else begin : g_next
        assign rem_prev  = rem_r[i-1];
        assign low_prev  = low_r[i-1];
        assign quot_prev = quot_r[i-1];
        assign tag_prev  = tag_r[i-1];
      end
      assign trial = {rem_prev, low_prev[QUOT_W-1-i]};
      assign ge    = (trial >= {1'b0, divisor});
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i]  <= ge ? NORM_W'(trial - {1'b0, divisor}) : trial[NORM_W-1:0];
          low_r[i]  <= low_prev;
          quot_r[i] <= {quot_prev[QUOT_W-2:0], ge};
          tag_r[i]  <= tag_prev;
        end
      end
    end
  endgenerate

  assign quot    = quot_r[QUOT_W-1];
  assign tag_out = tag_r[QUOT_W-1];

endmodule

// ----- hdl/sap_isqrt.sv -----
// ----------------------------------------------------------------------------
// sap_isqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module sap_isqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [sap_pkg::QUOT_W-1:0]  radicand,
  input  logic                        tag_in,
  output logic [sap_pkg::ROOT_W-1:0]  root,
  output logic                        tag_out
);
  import sap_pkg::*;

  logic [SQRT_REM_W-1:0] rem_r  [ROOT_W];
  logic [ROOT_W:0]       root_r [ROOT_W];
  logic [QUOT_W-1:0]     rad_r  [ROOT_W];
  logic                  tag_r  [ROOT_W];

  genvar j;
  generate
    for (j = 0; j < ROOT_W; j++) begin : g_stage
      logic [SQRT_REM_W-1:0] rem_prev;
      logic [ROOT_W:0]       root_prev;
      logic [QUOT_W-1:0]     rad_prev;
      logic                  tag_prev;
      logic [SQRT_REM_W-1:0] t;
      logic [SQRT_REM_W-1:0] trial;
      logic                  ge;
      if (j == 0) begin : g_first
        assign rem_prev  = '0;
        assign root_prev = '0;
        assign rad_prev  = radicand;
        assign tag_prev  = tag_in;
      end else begin : g_next
        assign rem_prev  = rem_r[j-1];
        assign root_prev = root_r[j-1];
        assign rad_prev  = rad_r[j-1];
        assign tag_prev  = tag_r[j-1];
      end
      assign t     = {rem_prev[SQRT_REM_W-3:0], rad_prev[QUOT_W-1-2*j -: 2]};
      assign trial = SQRT_REM_W'({root_prev, 2'b01});
      assign ge    = (t >= trial);
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j]  <= ge ? (t - trial) : t;
          root_r[j] <= {root_prev[ROOT_W-1:0], ge};
          rad_r[j]  <= rad_prev;
          tag_r[j]  <= tag_prev;
        end
      end
    end
  endgenerate

  assign root    = root_r[ROOT_W-1][ROOT_W-1:0];
  assign tag_out = tag_r[ROOT_W-1];

endmodule

// ----- hdl/sap_lane.sv -----
// ----------------------------------------------------------------------------
// sap_lane
// One axis: dot product, square, divide by norm, root and rounding.
// ----------------------------------------------------------------------------
module sap_lane (
  input  logic            clk,
  input  logic            en,
  input  sap_pkg::comp_t  s_x,
  input  sap_pkg::comp_t  s_y,
  input  sap_pkg::comp_t  s_z,
  input  sap_pkg::axis_t  axis,
  input  sap_pkg::norm_t  norm,
  output sap_pkg::res_t   comp
);
  import sap_pkg::*;

  logic signed [2*COMP_W-1:0] px_r, py_r, pz_r;
  logic signed [2*COMP_W+1:0] d_r;
  logic [MAG_W-1:0]           m_r;
  logic                       neg2_r, neg3_r;
  logic [2*MAG_W-1:0]         sq_prod;
  logic [SQ_W-1:0]            sq_r;
  logic [QUOT_W-1:0]          quot;
  logic                       neg_div;
  logic [ROOT_W-1:0]          root;
  logic                       neg_sq;
  logic [ROOT_W-1:0]          mag;
  res_t                       comp_r;

  assign sq_prod = (2*MAG_W)'(m_r) * (2*MAG_W)'(m_r);

  always_ff @(posedge clk) begin
    if (en) begin
      px_r   <= s_x * $signed(axis[COMP_W-1:0]);
      py_r   <= s_y * $signed(axis[2*COMP_W-1:COMP_W]);
      pz_r   <= s_z * $signed(axis[3*COMP_W-1:2*COMP_W]);
      d_r    <= (2*COMP_W+2)'(px_r) + (2*COMP_W+2)'(py_r) + (2*COMP_W+2)'(pz_r);
      neg2_r <= d_r[2*COMP_W+1];
      m_r    <= d_r[2*COMP_W+1] ? MAG_W'(-d_r) : MAG_W'(d_r);
      neg3_r <= neg2_r;
      sq_r   <= {sq_prod, 2'b00};
    end
  end

  sap_div u_div (
    .clk      (clk),
    .en       (en),
    .dividend (sq_r),
    .divisor  (norm),
    .tag_in   (neg3_r),
    .quot     (quot),
    .tag_out  (neg_div)
  );

  sap_isqrt u_isqrt (
    .clk      (clk),
    .en       (en),
    .radicand (quot),
    .tag_in   (neg_div),
    .root     (root),
    .tag_out  (neg_sq)
  );

  // nearest integer: largest odd <= root gives (odd+1)/2
  assign mag = ROOT_W'(({1'b0, root} + 1'b1) >> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      if (norm == '0) begin
        comp_r <= '0;
      end else if (neg_sq) begin
        comp_r <= -$signed({1'b0, mag[RES_W-2:0]});
      end else begin
        comp_r <= $signed({1'b0, mag[RES_W-2:0]});
      end
    end
  end

  assign comp = comp_r;

endmodule

// ----- hdl/signed_axis_projection.sv -----
// ----------------------------------------------------------------------------
// signed_axis_projection
// Signed length of a 3-axis sample along three configured axes.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | sample_x, sample_y, sample_z
//  out_    | output    | out_valid/out_stall| three components, zero flags
//  cfg_    | input     | cfg_we             | cfg_index, cfg_wdata
//
// One transaction per cycle while the output is not stalled; the path has
// 4 dot/square stages, 34 divider stages, 17 root stages and one output stage.
// Reset clears the pipeline valid bits and the axis registers.
// A stall at the output while out_valid is high freezes the whole pipeline and raises in_stall.
// ----------------------------------------------------------------------------
module signed_axis_projection (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  sap_pkg::comp_t          in_sample_x,
  input  sap_pkg::comp_t          in_sample_y,
  input  sap_pkg::comp_t          in_sample_z,
  output logic                    out_valid,
  input  logic                    out_stall,
  output sap_pkg::res_t           out_vertical_component,
  output sap_pkg::res_t           out_forward_component,
  output sap_pkg::res_t           out_lateral_component,
  output logic [2:0]              out_zero_axis_flags,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  sap_pkg::axis_t          cfg_wdata
);
  import sap_pkg::*;

  axis_t             axis_r [AXIS_COUNT];
  norm_t             norm_r [AXIS_COUNT];
  res_t              comp   [AXIS_COUNT];
  logic [LATENCY-1:0] valid_r;
  logic              en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < AXIS_COUNT; k++) axis_r[k] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VERTICAL: axis_r[0] <= cfg_wdata;
        REG_FORWARD:  axis_r[1] <= cfg_wdata;
        REG_LATERAL:  axis_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  genvar g;
  generate
    for (g = 0; g < AXIS_COUNT; g++) begin : g_axis
      logic signed [COMP_W-1:0] ax, ay, az;
      assign ax = axis_r[g][COMP_W-1:0];
      assign ay = axis_r[g][2*COMP_W-1:COMP_W];
      assign az = axis_r[g][3*COMP_W-1:2*COMP_W];
      always_ff @(posedge clk) begin
        norm_r[g] <= NORM_W'(ax * ax) + NORM_W'(ay * ay) + NORM_W'(az * az);
      end

      sap_lane u_lane (
        .clk  (clk),
        .en   (en),
        .s_x  (in_sample_x),
        .s_y  (in_sample_y),
        .s_z  (in_sample_z),
        .axis (axis_r[g]),
        .norm (norm_r[g]),
        .comp (comp[g])
      );
    end
  endgenerate

  assign en       = !(valid_r[LATENCY-1] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[LATENCY-2:0], in_valid};
    end
  end

  assign out_valid              = valid_r[LATENCY-1];
  assign out_vertical_component = comp[0];
  assign out_forward_component  = comp[1];
  assign out_lateral_component  = comp[2];
  assign out_zero_axis_flags    = {norm_r[2] == '0, norm_r[1] == '0, norm_r[0] == '0};

endmodule

// ----- hdl/sap_checker.sv -----
// ----------------------------------------------------------------------------
// sap_checker
// Port-level checks of the signed axis projection block.
// ----------------------------------------------------------------------------
module sap_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input sap_pkg::res_t   out_vertical_component,
  input sap_pkg::res_t   out_forward_component,
  input sap_pkg::res_t   out_lateral_component,
  input logic [2:0]      out_zero_axis_flags
);
  import sap_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_vertical_component) &&
      $stable(out_forward_component) && $stable(out_lateral_component))
    else $error("stalled transaction changed");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow output stall");

  a_zero_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_zero_axis_flags[0] || out_vertical_component == '0) &&
      (!out_zero_axis_flags[1] || out_forward_component == '0) &&
      (!out_zero_axis_flags[2] || out_lateral_component == '0))
    else $error("nonzero component on zero-length axis");

endmodule

bind signed_axis_projection sap_checker u_sap_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .in_stall               (in_stall),
  .out_valid              (out_valid),
  .out_stall              (out_stall),
  .out_vertical_component (out_vertical_component),
  .out_forward_component  (out_forward_component),
  .out_lateral_component  (out_lateral_component),
  .out_zero_axis_flags    (out_zero_axis_flags)
);
